// ===== rtl/core/foot_support_estimator_unit_defines.svh =====
// Assertion helpers for the foot support estimator checker.
// Both expect clk and arst_n in scope.
`ifndef FOOT_SUPPORT_ESTIMATOR_UNIT_DEFINES_SVH
`define FOOT_SUPPORT_ESTIMATOR_UNIT_DEFINES_SVH

// Consequent holds in the same cycle as the antecedent
`define FSE_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Consequent holds in the cycle after the antecedent
`define FSE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/fse_pkg.sv =====
`default_nettype none
package fse_pkg;

	localparam int SENSORS_PER_FOOT = 4;
	localparam int PRESS_W = 16;
	localparam int PROD_W = 32;
	localparam int SUM_W = 35;
	localparam int NUM_W = 50;
	localparam int DEN_W = 36;
	localparam int QUO_W = 15;
	localparam int CNT_W = 4;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;
	localparam int IN_DATA_W = 216;
	localparam int OUT_DATA_W = 56;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SENSOR_WEIGHTS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PRED_FACTOR = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CUR_PRED_FACTOR = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DISCOUNT_MIN = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_DISCOUNT_MAX = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_RATIO_MIN = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_RATIO_MAX = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_SIM_MODE = 3'd7;

	typedef struct packed {
		logic start;
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic [QUO_W-1:0] quo;
	} div_rsp_t;

	typedef enum logic [8:0] {
		ST_IDLE = 9'b000000001,
		ST_MUL  = 9'b000000010,
		ST_ADD  = 9'b000000100,
		ST_SUM  = 9'b000001000,
		ST_DDIV = 9'b000010000,
		ST_SDIV = 9'b000100000,
		ST_PRED = 9'b001000000,
		ST_CMP  = 9'b010000000,
		ST_DONE = 9'b100000000
	} state_t;

endpackage
`default_nettype wire

// ===== rtl/core/foot_support_estimator_unit.sv =====
// Foot support estimator.
// Input stream (s_axis_*): one frame per transfer with eight pressure samples,
// two leg currents, frame time, minimum pressure and status bits.
// Output stream (m_axis_*): exactly one result per input frame, in order.
// Configuration: cfg_we writes cfg_data into register cfg_index at a clock
// edge; write only while no frame is in flight.
// A frame with time zero goes straight to the done state. Other frames pass
// the multiply, add and sum states; a frame whose total pressure is not above
// the minimum then skips the divisions, others run the support division, and
// before it the discount map division if the map needs one. Both run on
// the one shared restoring divider (15 quotient bits). A new frame is taken
// in idle, entered as the previous result is loaded into the output register.
// The eight weight products run in parallel lanes and are merged by a sum
// stage. Reset clears all history and restores the register defaults.
// When the receiver stalls, the result stays in the output register and the
// block may finish one further frame, then waits holding it.
`default_nettype none
module foot_support_estimator_unit import fse_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	// left_pressures, right_pressures, left_current, right_current, frame_time,
	// min_pressure, pressure_calibrated, left_has_pressure, right_has_pressure
	input  wire logic [IN_DATA_W-1:0]    s_axis_tdata,
	input  wire logic                    s_axis_tvalid,
	output logic                         s_axis_tready,
	// support, trusted, switched, predicted_switched, switch_interval
	output logic      [OUT_DATA_W-1:0]   m_axis_tdata,
	output logic                         m_axis_tvalid,
	input  wire logic                    m_axis_tready,
	input  wire logic                    cfg_we,
	input  wire logic [CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [CFG_DATA_W-1:0]   cfg_data
);

	// Configuration registers
	logic [31:0]        weights_q;
	logic signed [15:0] pf_q;
	logic signed [15:0] cpf_q;
	logic [14:0]        dmin_q;
	logic [14:0]        dmax_q;
	logic [15:0]        crmin_q;
	logic [15:0]        crmax_q;
	logic               sim_q;

	// History
	logic signed [15:0] prev_sup_q;
	logic signed [15:0] prev_psup_q;
	logic [15:0]        prev_lc_q;
	logic [15:0]        prev_rc_q;
	logic [31:0]        last_sw_q;
	logic signed [15:0] h_sup_q;
	logic               h_trust_q;
	logic               h_sw_q;
	logic               h_psw_q;
	logic [31:0]        h_int_q;

	// Frame payload
	logic [63:0] lp_q;
	logic [63:0] rp_q;
	logic [15:0] lc_q;
	logic [15:0] rc_q;
	logic [31:0] time_q;
	logic [15:0] minp_q;
	logic        calib_q;
	logic        lhp_q;
	logic        rhp_q;

	state_t state_q;
	logic   skip_q;
	logic   hp_q;
	logic   div_start_q;

	// Working registers
	logic signed [34:0]  pred0_q;
	logic signed [34:0]  pred1_q;
	logic [42:0]         dnum_q;
	logic [27:0]         dden_q;
	logic                dneg_q;
	logic [NUM_W-1:0]    snum_q;
	logic [DEN_W-1:0]    sden_q;
	logic                wneg_q;
	logic [14:0]         disc_q;
	logic signed [15:0]  s_q;
	logic signed [16:0]  ds_q;
	logic signed [34:0]  psup_q;
	logic [29:0]         dsq_q;
	logic signed [50:0]  prod_q;

	logic [OUT_DATA_W-1:0] out_q;
	logic                  ovalid_q;

	logic [15:0] weight_outer;
	logic [15:0] weight_inner;
	logic [PROD_W-1:0] lprod [SENSORS_PER_FOOT];
	logic [PROD_W-1:0] rprod [SENSORS_PER_FOOT];
	logic signed [SUM_W-1:0] wsum_s2;
	logic [SUM_W-1:0]        total_s2;

	div_req_t div_req;
	div_rsp_t div_rsp;

	logic in_fire;
	logic out_free;

	assign weight_outer = weights_q[15:0];
	assign weight_inner = weights_q[31:16];
	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_fire = s_axis_tvalid && s_axis_tready;
	assign out_free = !ovalid_q || m_axis_tready;
	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata = out_q;

	// Weight lanes: left outer sensors are even, right outer sensors are odd
	for (genvar k = 0; k < SENSORS_PER_FOOT; k++) begin : g_lane
		fse_lane u_lane_l (
			.clk(clk),
			.en(state_q == ST_MUL),
			.pressure(lp_q[k*PRESS_W +: PRESS_W]),
			.weight((k % 2 == 0) ? weight_outer : weight_inner),
			.prod_s1(lprod[k])
		);
		fse_lane u_lane_r (
			.clk(clk),
			.en(state_q == ST_MUL),
			.pressure(rp_q[k*PRESS_W +: PRESS_W]),
			.weight((k % 2 == 0) ? weight_inner : weight_outer),
			.prod_s1(rprod[k])
		);
	end

	fse_merge u_merge (
		.clk(clk),
		.en(state_q == ST_ADD),
		.left_prod(lprod),
		.right_prod(rprod),
		.wsum_s2(wsum_s2),
		.total_s2(total_s2)
	);

	// Shared divider
	assign div_req.start = div_start_q;
	assign div_req.num = (state_q == ST_DDIV) ? NUM_W'(dnum_q) : snum_q;
	assign div_req.den = (state_q == ST_DDIV) ? DEN_W'(dden_q) : sden_q;

	fse_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.req(div_req),
		.rsp(div_rsp)
	);

	// Predicted leg currents
	logic signed [16:0] dcur0;
	logic signed [16:0] dcur1;
	logic signed [32:0] cp0;
	logic signed [32:0] cp1;
	logic signed [34:0] pred0_c;
	logic signed [34:0] pred1_c;

	always_comb begin
		dcur0 = $signed({1'b0, lc_q}) - $signed({1'b0, prev_lc_q});
		dcur1 = $signed({1'b0, rc_q}) - $signed({1'b0, prev_rc_q});
		cp0 = dcur0 * cpf_q;
		cp1 = dcur1 * cpf_q;
		pred0_c = $signed({7'b0, lc_q, 12'b0}) + $signed({{2{cp0[32]}}, cp0});
		pred1_c = $signed({7'b0, rc_q, 12'b0}) + $signed({{2{cp1[32]}}, cp1});
	end

	// Discount map and support division operands
	logic signed [35:0] psum;
	logic signed [34:0] xsel;
	logic signed [34:0] lo_c;
	logic signed [34:0] hi_c;
	logic signed [34:0] xoff;
	logic signed [15:0] dspan;
	logic [14:0]        dmag;
	logic               hp_c;
	logic signed [34:0] wmag;

	always_comb begin
		psum = $signed({pred0_q[34], pred0_q}) + $signed({pred1_q[34], pred1_q});
		xsel = (prev_sup_q > 16'sd0) ? pred1_q : pred0_q;
		lo_c = $signed({7'b0, crmin_q, 12'b0});
		hi_c = $signed({7'b0, crmax_q, 12'b0});
		xoff = xsel - lo_c;
		dspan = $signed({1'b0, dmax_q}) - $signed({1'b0, dmin_q});
		dmag = (dspan < 16'sd0) ? 15'(-dspan) : dspan[14:0];
		hp_c = total_s2 > {5'b0, minp_q, 14'b0};
		wmag = (wsum_s2 < 35'sd0) ? -wsum_s2 : wsum_s2;
	end

	// Prediction terms
	logic signed [16:0] ds_c;
	logic signed [32:0] pfd_c;

	always_comb begin
		ds_c = $signed({s_q[15], s_q}) - $signed({prev_sup_q[15], prev_sup_q});
		pfd_c = pf_q * ds_c;
	end

	// Result of the frame
	logic signed [50:0] thr;
	logic               opp;
	logic [15:0]        abs_s;
	logic               foot_ok;
	logic               sign_chg;
	logic               sw_c;
	logic               psw_c;
	logic [31:0]        int_c;
	logic signed [15:0] r_sup;
	logic               r_trust;
	logic               r_sw;
	logic               r_psw;
	logic [31:0]        r_int;

	always_comb begin
		thr = $signed({9'b0, dsq_q, 12'b0});
		opp = (ds_q < 17'sd0 && s_q > 16'sd0) || (ds_q > 17'sd0 && s_q < 16'sd0);
		abs_s = (s_q < 16'sd0) ? 16'(-s_q) : s_q;
		foot_ok = (lhp_q && s_q > 16'sd0) || (rhp_q && s_q < 16'sd0);
		sign_chg = (prev_psup_q < 16'sd0 && s_q > 16'sd0) ||
			(prev_psup_q > 16'sd0 && s_q < 16'sd0) ||
			(prev_sup_q == 16'sd0 && s_q != 16'sd0);
		sw_c = sign_chg && foot_ok;
		psw_c = calib_q && (prod_q < thr) && opp && (abs_s < {1'b0, dmax_q});
		int_c = time_q - last_sw_q;
		if (skip_q) begin
			r_sup = h_sup_q;
			r_trust = h_trust_q;
			r_sw = h_sw_q;
			r_psw = h_psw_q;
			r_int = h_int_q;
		end else if (!hp_q) begin
			r_sup = '0;
			r_trust = 1'b0;
			r_sw = 1'b0;
			r_psw = 1'b0;
			r_int = h_int_q;
		end else begin
			r_sup = s_q;
			r_trust = calib_q;
			r_sw = sw_c;
			r_psw = psw_c;
			r_int = sw_c ? int_c : h_int_q;
		end
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weights_q <= 32'd322125824;
			pf_q <= 16'sd4096;
			cpf_q <= '0;
			dmin_q <= '0;
			dmax_q <= 15'd16384;
			crmin_q <= '0;
			crmax_q <= 16'hFFFF;
			sim_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SENSOR_WEIGHTS: weights_q <= cfg_data;
				CFG_PRED_FACTOR: pf_q <= $signed(cfg_data[15:0]);
				CFG_CUR_PRED_FACTOR: cpf_q <= $signed(cfg_data[15:0]);
				CFG_DISCOUNT_MIN: dmin_q <= cfg_data[14:0];
				CFG_DISCOUNT_MAX: dmax_q <= cfg_data[14:0];
				CFG_RATIO_MIN: crmin_q <= cfg_data[15:0];
				CFG_RATIO_MAX: crmax_q <= cfg_data[15:0];
				CFG_SIM_MODE: sim_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Sequencer, history and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			div_start_q <= 1'b0;
			ovalid_q <= 1'b0;
			prev_sup_q <= '0;
			prev_psup_q <= '0;
			prev_lc_q <= '0;
			prev_rc_q <= '0;
			last_sw_q <= '0;
			h_sup_q <= '0;
			h_trust_q <= 1'b0;
			h_sw_q <= 1'b0;
			h_psw_q <= 1'b0;
			h_int_q <= '0;
		end else begin
			div_start_q <= 1'b0;
			if (ovalid_q && m_axis_tready) begin
				ovalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						state_q <= (s_axis_tdata[191:160] == 32'd0) ? ST_DONE : ST_MUL;
					end
				end
				ST_MUL: state_q <= ST_ADD;
				ST_ADD: state_q <= ST_SUM;
				ST_SUM: begin
					if (!hp_c) begin
						state_q <= ST_DONE;
					end else if (!sim_q && psum != 36'sd0 && xsel > lo_c && xsel < hi_c) begin
						state_q <= ST_DDIV;
						div_start_q <= 1'b1;
					end else begin
						state_q <= ST_SDIV;
						div_start_q <= 1'b1;
					end
				end
				ST_DDIV: begin
					if (div_rsp.done) begin
						state_q <= ST_SDIV;
						div_start_q <= 1'b1;
					end
				end
				ST_SDIV: begin
					if (div_rsp.done) begin
						state_q <= ST_PRED;
					end
				end
				ST_PRED: state_q <= ST_CMP;
				ST_CMP: state_q <= ST_DONE;
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
						ovalid_q <= 1'b1;
						if (!skip_q) begin
							h_sup_q <= r_sup;
							h_trust_q <= r_trust;
							h_sw_q <= r_sw;
							h_psw_q <= r_psw;
							h_int_q <= r_int;
							prev_lc_q <= lc_q;
							prev_rc_q <= rc_q;
							if (hp_q) begin
								prev_sup_q <= s_q;
								if (foot_ok) begin
									prev_psup_q <= s_q;
								end
								if (sw_c) begin
									last_sw_q <= time_q;
								end
							end
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			lp_q <= s_axis_tdata[63:0];
			rp_q <= s_axis_tdata[127:64];
			lc_q <= s_axis_tdata[143:128];
			rc_q <= s_axis_tdata[159:144];
			time_q <= s_axis_tdata[191:160];
			minp_q <= s_axis_tdata[207:192];
			calib_q <= s_axis_tdata[208];
			lhp_q <= s_axis_tdata[209];
			rhp_q <= s_axis_tdata[210];
			skip_q <= (s_axis_tdata[191:160] == 32'd0);
			hp_q <= 1'b0;
		end
		if (state_q == ST_ADD) begin
			pred0_q <= pred0_c;
			pred1_q <= pred1_c;
		end
		if (state_q == ST_SUM) begin
			hp_q <= hp_c;
			dnum_q <= xoff[27:0] * dmag;
			dden_q <= 28'(hi_c - lo_c);
			dneg_q <= dspan < 16'sd0;
			snum_q <= {1'b0, wmag[33:0], 15'b0} + {15'b0, total_s2};
			sden_q <= {total_s2, 1'b0};
			wneg_q <= wsum_s2 < 35'sd0;
			if (sim_q || psum == 36'sd0 || xsel <= lo_c) begin
				disc_q <= dmin_q;
			end else if (xsel >= hi_c) begin
				disc_q <= dmax_q;
			end
		end
		if (state_q == ST_DDIV && div_rsp.done) begin
			disc_q <= dneg_q ? dmin_q - div_rsp.quo : dmin_q + div_rsp.quo;
		end
		if (state_q == ST_SDIV && div_rsp.done) begin
			s_q <= wneg_q ? -$signed({1'b0, div_rsp.quo}) : $signed({1'b0, div_rsp.quo});
		end
		if (state_q == ST_PRED) begin
			ds_q <= ds_c;
			psup_q <= $signed({{7{s_q[15]}}, s_q, 12'b0}) + $signed({{2{pfd_c[32]}}, pfd_c});
			dsq_q <= disc_q * disc_q;
		end
		if (state_q == ST_CMP) begin
			prod_q <= psup_q * s_q;
		end
		if (state_q == ST_DONE && out_free) begin
			out_q <= {5'b0, r_int, r_psw, r_sw, r_trust, r_sup};
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/fse_lane.sv =====
`default_nettype none
module fse_lane import fse_pkg::*; (
	input  wire logic               clk,
	input  wire logic               en,
	input  wire logic [PRESS_W-1:0] pressure,
	input  wire logic [PRESS_W-1:0] weight,
	output logic      [PROD_W-1:0]  prod_s1
);

	// Weigh one sensor sample
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= pressure * weight;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/fse_merge.sv =====
`default_nettype none
module fse_merge import fse_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     en,
	input  wire logic [PROD_W-1:0]        left_prod [SENSORS_PER_FOOT],
	input  wire logic [PROD_W-1:0]        right_prod [SENSORS_PER_FOOT],
	output logic signed [SUM_W-1:0]       wsum_s2,
	output logic        [SUM_W-1:0]       total_s2
);

	logic [SUM_W-2:0] sum_l;
	logic [SUM_W-2:0] sum_r;

	// Add up each foot
	always_comb begin
		sum_l = '0;
		sum_r = '0;
		for (int k = 0; k < SENSORS_PER_FOOT; k++) begin
			sum_l = sum_l + (SUM_W-1)'(left_prod[k]);
			sum_r = sum_r + (SUM_W-1)'(right_prod[k]);
		end
	end

	// Form signed balance and total
	always_ff @(posedge clk) begin
		if (en) begin
			wsum_s2 <= $signed({1'b0, sum_l}) - $signed({1'b0, sum_r});
			total_s2 <= {1'b0, sum_l} + {1'b0, sum_r};
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/fse_div.sv =====
`default_nettype none
module fse_div import fse_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire div_req_t req,
	output div_rsp_t      rsp
);

	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [QUO_W-1:0] sh_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   trial;
	logic             ge;

	// One quotient bit per step; quotient is known to fit QUO_W bits
	assign trial = {rem_q, sh_q[QUO_W-1]};
	assign ge = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= CNT_W'(QUO_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Load operands, then shift and subtract
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= DEN_W'(req.num[NUM_W-1:QUO_W]);
			sh_q <= req.num[QUO_W-1:0];
			den_q <= req.den;
		end else if (busy_q) begin
			rem_q <= ge ? DEN_W'(trial - {1'b0, den_q}) : DEN_W'(trial);
			sh_q <= {sh_q[QUO_W-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo = sh_q;

endmodule
`default_nettype wire

// ===== rtl/core/fse_checker.sv =====
`default_nettype none
`include "foot_support_estimator_unit_defines.svh"
module fse_checker import fse_pkg::*; (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic [IN_DATA_W-1:0]  s_axis_tdata,
	input wire logic                  s_axis_tvalid,
	input wire logic                  s_axis_tready,
	input wire logic [OUT_DATA_W-1:0] m_axis_tdata,
	input wire logic                  m_axis_tvalid,
	input wire logic                  m_axis_tready,
	input wire logic                  cfg_we,
	input wire logic [CFG_IDX_W-1:0]  cfg_index,
	input wire logic [CFG_DATA_W-1:0] cfg_data
);

	logic signed [15:0] sup;
	assign sup = $signed(m_axis_tdata[15:0]);

	// A stalled result stays offered
	`FSE_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped while stalled")
	// Support never leaves the unit range
	`FSE_ASSERT_SAME(a_sup_range, m_axis_tvalid, sup >= -16'sd16384 && sup <= 16'sd16384, "support out of range")
	// A switch or predicted switch needs a nonzero support
	`FSE_ASSERT_SAME(a_flag_sup, m_axis_tvalid && (m_axis_tdata[17] || m_axis_tdata[18]), sup != 16'sd0, "switch flag with zero support")
	// One frame at a time: input closes after a transfer
	`FSE_ASSERT_NEXT(a_one_frame, s_axis_tvalid && s_axis_tready, !s_axis_tready, "second frame taken while busy")

endmodule

bind foot_support_estimator_unit fse_checker u_fse_checker (.*);
`default_nettype wire

// ===== sim/foot_support_estimator_unit_tb.sv =====
`default_nettype none
module foot_support_estimator_unit_tb import fse_pkg::*;;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 100;

	typedef struct packed {
		logic        right_has_pressure;
		logic        left_has_pressure;
		logic        pressure_calibrated;
		logic [15:0] min_pressure;
		logic [31:0] frame_time;
		logic [15:0] right_current;
		logic [15:0] left_current;
		logic [63:0] right_pressures;
		logic [63:0] left_pressures;
	} frame_t;

	typedef struct packed {
		logic [31:0] switch_interval;
		logic        predicted_switched;
		logic        switched;
		logic        trusted;
		logic [15:0] support;
	} estimate_t;

	logic clk;
	logic arst_n;
	logic [IN_DATA_W-1:0] s_axis_tdata;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	foot_support_estimator_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tdata(s_axis_tdata), .s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// register copies
	logic [31:0] m_weights;
	logic signed [15:0] m_pred_gain;
	logic signed [15:0] m_cur_gain;
	logic [14:0] m_disc_min;
	logic [14:0] m_disc_max;
	logic [15:0] m_ratio_min;
	logic [15:0] m_ratio_max;
	logic m_sim_mode;

	// estimator history
	longint m_prev_support;
	longint m_prev_pressured;
	longint m_prev_cur [2];
	logic [31:0] m_last_switch;
	estimate_t m_held;

	frame_t pending_frames[$];
	estimate_t expected_estimates[$];
	int error_count = 0;
	int frames_sent = 0;
	int estimates_seen = 0;
	int switches_seen = 0;
	int predictions_seen = 0;
	int idle_cycles = 0;
	bit long_stall = 0;
	bit timed_out = 0;
	bit in_taken = 0;

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	function automatic void reset_model();
		m_weights = 32'd322125824;
		m_pred_gain = 16'sd4096;
		m_cur_gain = 16'sd0;
		m_disc_min = 15'd0;
		m_disc_max = 15'd16384;
		m_ratio_min = 16'd0;
		m_ratio_max = 16'd65535;
		m_sim_mode = 1'b0;
		m_prev_support = 0;
		m_prev_pressured = 0;
		m_prev_cur[0] = 0;
		m_prev_cur[1] = 0;
		m_last_switch = '0;
		m_held = '0;
	endfunction

	function automatic longint discount_from_current(longint x12);
		longint lo;
		longint hi;
		lo = longint'(m_ratio_min) * 4096;
		hi = longint'(m_ratio_max) * 4096;
		if (x12 <= lo)
			return longint'(m_disc_min);
		if (x12 >= hi)
			return longint'(m_disc_max);
		return longint'(m_disc_min) + ((x12 - lo) *
			(longint'(m_disc_max) - longint'(m_disc_min))) / (hi - lo);
	endfunction

	// predict one estimate and advance the history
	function automatic estimate_t estimate_support(frame_t f);
		estimate_t r;
		longint outer_w;
		longint inner_w;
		longint wsum;
		longint total;
		longint pl;
		longint pr;
		longint wl;
		longint wr;
		longint cur [2];
		longint pred [2];
		longint discount;
		longint mag;
		longint q;
		longint s;
		longint ds;
		longint psup;
		longint abs_s;
		bit foot_ok;
		bit sign_change;
		if (f.frame_time == 0)
			return m_held;
		outer_w = longint'(m_weights[15:0]);
		inner_w = longint'(m_weights[31:16]);
		wsum = 0;
		total = 0;
		for (int k = 0; k < SENSORS_PER_FOOT; k++) begin
			pl = longint'(f.left_pressures[16*k +: 16]);
			pr = longint'(f.right_pressures[16*k +: 16]);
			wl = pl * ((k % 2 == 0) ? outer_w : inner_w);
			wr = pr * ((k % 2 == 0) ? inner_w : outer_w);
			wsum += wl - wr;
			total += wl + wr;
		end
		cur[0] = longint'(f.left_current);
		cur[1] = longint'(f.right_current);
		for (int leg = 0; leg < 2; leg++)
			pred[leg] = cur[leg] * 4096 + (cur[leg] - m_prev_cur[leg]) * longint'(m_cur_gain);
		if (m_sim_mode || pred[0] + pred[1] == 0)
			discount = longint'(m_disc_min);
		else
			discount = discount_from_current(m_prev_support > 0 ? pred[1] : pred[0]);
		r = '0;
		r.switch_interval = m_held.switch_interval;
		if (total > longint'(f.min_pressure) * 16384) begin
			mag = wsum < 0 ? -wsum : wsum;
			q = (mag * 32768 + total) / (2 * total);
			s = wsum < 0 ? -q : q;
			ds = s - m_prev_support;
			psup = s * 4096 + longint'(m_pred_gain) * ds;
			foot_ok = (f.left_has_pressure && s > 0) || (f.right_has_pressure && s < 0);
			sign_change = (m_prev_pressured * s < 0) || (m_prev_support == 0 && s != 0);
			abs_s = s < 0 ? -s : s;
			r.support = 16'(s);
			r.trusted = f.pressure_calibrated;
			r.switched = sign_change && foot_ok;
			if (foot_ok)
				m_prev_pressured = s;
			if (r.switched) begin
				r.switch_interval = f.frame_time - m_last_switch;
				m_last_switch = f.frame_time;
			end
			r.predicted_switched = f.pressure_calibrated && psup * s < discount * discount * 4096
				&& ds * s < 0 && abs_s < longint'(m_disc_max);
			m_prev_support = s;
		end
		m_prev_cur[0] = cur[0];
		m_prev_cur[1] = cur[1];
		m_held = r;
		return r;
	endfunction

	function automatic logic [15:0] rand_pressure();
		case ($urandom_range(0, 9))
			0: return 16'd0;
			1: return 16'hFFFF;
			2, 3: return 16'($urandom);
			default: return 16'($urandom_range(0, 8192));
		endcase
	endfunction

	function automatic frame_t rand_frame(logic [31:0] t);
		frame_t f;
		bit lean_left;
		lean_left = $urandom_range(0, 1);
		for (int k = 0; k < 4; k++) begin
			f.left_pressures[16*k +: 16] = rand_pressure();
			f.right_pressures[16*k +: 16] = rand_pressure();
		end
		// mostly stand on one foot to drive switches
		if ($urandom_range(0, 3) != 0) begin
			if (lean_left)
				f.right_pressures = f.right_pressures >> (4 + $urandom_range(0, 8));
			else
				f.left_pressures = f.left_pressures >> (4 + $urandom_range(0, 8));
		end
		f.left_current = $urandom_range(0, 5) == 0 ? 16'($urandom) : 16'($urandom_range(0, 3000));
		f.right_current = $urandom_range(0, 5) == 0 ? 16'($urandom) : 16'($urandom_range(0, 3000));
		f.frame_time = t;
		case ($urandom_range(0, 9))
			0: f.min_pressure = 16'($urandom);
			1: f.min_pressure = 16'hFFFF;
			default: f.min_pressure = 16'($urandom_range(0, 2048));
		endcase
		f.pressure_calibrated = $urandom_range(0, 7) != 0;
		f.left_has_pressure = $urandom_range(0, 5) != 0;
		f.right_has_pressure = $urandom_range(0, 5) != 0;
		return f;
	endfunction

	// write one register at the falling edge, mirror it in the model
	task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_SENSOR_WEIGHTS: m_weights = val;
			CFG_PRED_FACTOR: m_pred_gain = val[15:0];
			CFG_CUR_PRED_FACTOR: m_cur_gain = val[15:0];
			CFG_DISCOUNT_MIN: m_disc_min = val[14:0];
			CFG_DISCOUNT_MAX: m_disc_max = val[14:0];
			CFG_RATIO_MIN: m_ratio_min = val[15:0];
			CFG_RATIO_MAX: m_ratio_max = val[15:0];
			CFG_SIM_MODE: m_sim_mode = val[0];
			default: ;
		endcase
	endtask

	task automatic wait_drained();
		while (pending_frames.size() != 0 || expected_estimates.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic queue_frame(frame_t f);
		pending_frames.push_back(f);
		expected_estimates.push_back(estimate_support(f));
	endtask

	// note an input transfer at the rising edge
	always @(posedge clk) begin
		in_taken <= arst_n && s_axis_tvalid && s_axis_tready;
	end

	// driver: offer queued frames with random gaps
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
		end else begin
			if (in_taken)
				void'(pending_frames.pop_front());
			if (s_axis_tvalid && !in_taken) begin
				// hold the current transfer
			end else if (pending_frames.size() > 0 && $urandom_range(0, 3) != 0) begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= IN_DATA_W'(pending_frames[0]);
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// receiver back pressure: short random stalls, and one long hold-off
	int stall_count = 0;
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (long_stall) begin
			m_axis_tready <= 1'b0;
		end else if (stall_count > 0) begin
			stall_count <= stall_count - 1;
			m_axis_tready <= 1'b0;
		end else if ($urandom_range(0, 15) == 0) begin
			stall_count <= $urandom_range(0, 9) == 0 ? $urandom_range(20, 120)
				: $urandom_range(1, 4);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// monitor: compare each output transfer with the oldest prediction
	always @(posedge clk) begin
		estimate_t got;
		estimate_t want;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				frames_sent++;
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata[$bits(estimate_t)-1:0];
				estimates_seen++;
				if (got.switched)
					switches_seen++;
				if (got.predicted_switched)
					predictions_seen++;
				if (expected_estimates.size() == 0) begin
					error_count++;
					$display("%0t: unexpected result %h", $time, got);
				end else begin
					want = expected_estimates.pop_front();
					if (got !== want) begin
						error_count++;
						$display("%0t: mismatch expected support=%h trusted=%b sw=%b psw=%b int=%h",
							$time, want.support, want.trusted, want.switched,
							want.predicted_switched, want.switch_interval);
						$display("%0t:          actual   support=%h trusted=%b sw=%b psw=%b int=%h",
							$time, got.support, got.trusted, got.switched,
							got.predicted_switched, got.switch_interval);
					end
				end
			end
		end
	end

	// watchdog on cycles with no transfer
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
			|| (pending_frames.size() == 0 && expected_estimates.size() == 0) || long_stall)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Watchdog expired with %0d results outstanding", expected_estimates.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		frame_t f;
		logic [31:0] t;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		reset_model();
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: extremes, not-started frames, low pressure, interval wrap
		f = '0;
		f.frame_time = 32'd0;
		queue_frame(f);
		f.frame_time = 32'd10;
		queue_frame(f);
		f.left_pressures = '1;
		f.right_pressures = '0;
		f.left_has_pressure = 1'b1;
		f.pressure_calibrated = 1'b1;
		f.frame_time = 32'hFFFF_FFF0;
		queue_frame(f);
		f.left_pressures = '0;
		f.right_pressures = '1;
		f.right_has_pressure = 1'b1;
		f.frame_time = 32'd20;
		f.left_current = 16'hFFFF;
		f.right_current = 16'hFFFF;
		queue_frame(f);
		f.frame_time = 32'd0;
		queue_frame(f);
		f.min_pressure = 16'hFFFF;
		f.frame_time = 32'd30;
		queue_frame(f);
		f.min_pressure = 16'd0;
		f.left_pressures = '1;
		f.frame_time = 32'hFFFF_FFFF;
		queue_frame(f);
		f.left_pressures = {16'h0, 16'hFFFF, 16'h0, 16'hFFFF};
		f.right_pressures = {16'h1000, 16'h0, 16'h1000, 16'h0};
		f.left_current = 16'd0;
		f.right_current = 16'd0;
		f.frame_time = 32'd40;
		queue_frame(f);
		wait_drained();

		// random phases over several register settings
		t = 32'd100;
		for (int phase = 0; phase < 8; phase++) begin
			case (phase)
				0: ;
				1: begin
					write_register(CFG_SENSOR_WEIGHTS, 32'hFFFF_FFFF);
					write_register(CFG_PRED_FACTOR, 32'h0000_7FFF);
					write_register(CFG_CUR_PRED_FACTOR, 32'h0000_8000);
					write_register(CFG_DISCOUNT_MIN, 32'd16384);
					write_register(CFG_DISCOUNT_MAX, 32'd16384);
				end
				2: begin
					write_register(CFG_SENSOR_WEIGHTS, 32'h0000_0000);
					write_register(CFG_SIM_MODE, 32'd1);
				end
				3: begin
					write_register(CFG_SENSOR_WEIGHTS, 32'h4000_2000);
					write_register(CFG_SIM_MODE, 32'd0);
					write_register(CFG_PRED_FACTOR, 32'h0000_8000);
					write_register(CFG_CUR_PRED_FACTOR, 32'h0000_7FFF);
					write_register(CFG_DISCOUNT_MIN, 32'd2000);
					write_register(CFG_DISCOUNT_MAX, 32'd12000);
					write_register(CFG_RATIO_MIN, 32'd200);
					write_register(CFG_RATIO_MAX, 32'd2500);
				end
				4: begin
					write_register(CFG_RATIO_MIN, 32'd3000);
					write_register(CFG_RATIO_MAX, 32'd1000);
					write_register(CFG_CUR_PRED_FACTOR, 32'h0000_1000);
				end
				5: begin
					write_register(CFG_RATIO_MIN, 32'd65535);
					write_register(CFG_RATIO_MAX, 32'd0);
					write_register(CFG_DISCOUNT_MIN, 32'd0);
					write_register(CFG_DISCOUNT_MAX, 32'd0);
				end
				6: begin
					write_register(CFG_SENSOR_WEIGHTS, {16'($urandom), 16'($urandom)});
					write_register(CFG_PRED_FACTOR, $urandom);
					write_register(CFG_CUR_PRED_FACTOR, $urandom);
					write_register(CFG_DISCOUNT_MIN, $urandom_range(0, 8000));
					write_register(CFG_DISCOUNT_MAX, $urandom_range(8000, 16384));
					write_register(CFG_RATIO_MIN, $urandom_range(0, 1000));
					write_register(CFG_RATIO_MAX, $urandom_range(1000, 4000));
				end
				default: begin
					write_register(CFG_SENSOR_WEIGHTS, 32'd322125824);
					write_register(CFG_PRED_FACTOR, 32'd4096);
					write_register(CFG_DISCOUNT_MIN, 32'd0);
					write_register(CFG_DISCOUNT_MAX, 32'd16384);
					write_register(CFG_RATIO_MIN, 32'd0);
					write_register(CFG_RATIO_MAX, 32'd65535);
				end
			endcase
			for (int n = 0; n < 180; n++) begin
				t = t + $urandom_range(1, 40);
				if ($urandom_range(0, 199) == 0)
					t = t + $urandom;
				f = rand_frame(($urandom_range(0, 30) == 0) ? 32'd0 : t);
				queue_frame(f);
			end
			// hold off the receiver for a long stretch while frames keep coming
			if (phase == 2) begin
				repeat (40) @(negedge clk);
				long_stall = 1;
				repeat (400) @(negedge clk);
				long_stall = 0;
			end
			wait_drained();
		end

		$display("Sent %0d frames, checked %0d results (%0d switches, %0d predicted)",
			frames_sent, estimates_seen, switches_seen, predictions_seen);
		$display("Covered eight register settings including extremes and a long output stall");
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
`default_nettype wire
